### design/xts_pkg.sv
// Shared types, character codes and helpers for the XML token scanner.
package xts_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int MAX_TOKENS      = 4;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    typedef enum logic [3:0] {
        TK_STRAY   = 4'd0,
        TK_EOF     = 4'd1,
        TK_LT      = 4'd2,
        TK_GT      = 4'd3,
        TK_LT_SL   = 4'd4,
        TK_SL_GT   = 4'd5,
        TK_LT_Q    = 4'd6,
        TK_Q_GT    = 4'd7,
        TK_NAME    = 4'd8,
        TK_EQ      = 4'd9,
        TK_STRING  = 4'd10,
        TK_TEXT    = 4'd11,
        TK_COMMENT = 4'd12
    } kind_t;

    typedef enum logic [3:0] {
        M_IDLE         = 4'd0,
        M_LT           = 4'd1,
        M_LT_BANG      = 4'd2,
        M_LT_BANG_DASH = 4'd3,
        M_SLASH        = 4'd4,
        M_QUEST        = 4'd5,
        M_NAME         = 4'd6,
        M_STRING       = 4'd7,
        M_TEXT         = 4'd8,
        M_COMMENT      = 4'd9
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] start;
        logic [23:0] len;
        logic [15:0] line;
        logic [15:0] col;
    } token_t;

    // all tokens one input item causes, in order
    typedef struct packed {
        logic [2:0]                  cnt;
        token_t [MAX_TOKENS-1:0]     tok;
    } bundle_t;

    function automatic logic [15:0] inc_sat(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_USCORE;
    endfunction

    function automatic logic is_name_char(input logic [7:0] b);
        return is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || b == CH_COLON || b == CH_DASH;
    endfunction

    function automatic logic is_quote(input logic [7:0] b);
        return b == CH_DQ || b == CH_SQ;
    endfunction

endpackage

### design/xts_front.sv
// Front end: takes one byte per valid cycle, tracks scan state, builds the token bundle.
module xts_front #(
    parameter int OFFSET_BITS = xts_pkg::OFFSET_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    input  logic             in_eoi,
    output logic             bnd_valid,
    output xts_pkg::bundle_t bnd
);
    import xts_pkg::*;

    localparam int OB = OFFSET_BITS;

    logic [OB-1:0] off_reg, off_next;
    logic [15:0]   line_reg, line_next;
    logic [15:0]   col_reg, col_next;
    logic          tag_reg, tag_next;
    mode_t         mode_reg, mode_next;
    logic [OB-1:0] pst_reg, pst_next;
    logic [15:0]   pline_reg, pline_next;
    logic [15:0]   pcol_reg, pcol_next;
    logic [1:0]    dash_reg, dash_next;

    function automatic logic [23:0] to24(input logic [OB-1:0] v);
        logic [OB+23:0] e;
        e = {24'b0, v};
        return e[23:0];
    endfunction

    function automatic token_t mk(input kind_t k, input logic [OB-1:0] s,
                                  input logic [OB-1:0] l, input logic [15:0] ln,
                                  input logic [15:0] cl);
        token_t t;
        t.kind  = k;
        t.start = to24(s);
        t.len   = to24(l);
        t.line  = ln;
        t.col   = cl;
        return t;
    endfunction

    always_comb
    begin
        logic [2:0]    n;
        token_t [MAX_TOKENS-1:0] tk;
        logic [15:0]   ln;
        logic [15:0]   cl;
        logic [15:0]   col1;
        logic [OB-1:0] upto;
        logic [OB-1:0] thru;
        logic          do_idle;
        logic [1:0]    held;
        logic          replay;

        n = '0;
        tk = '0;
        off_next = off_reg;
        line_next = line_reg;
        col_next = col_reg;
        tag_next = tag_reg;
        mode_next = mode_reg;
        pst_next = pst_reg;
        pline_next = pline_reg;
        pcol_next = pcol_reg;
        dash_next = dash_reg;
        do_idle = 1'b0;
        replay = 1'b0;
        held = 2'd0;
        col1 = inc_sat(pcol_reg);
        ln = line_reg;
        cl = col_reg;
        upto = off_reg - pst_reg;
        thru = off_reg + OB'(1) - pst_reg;

        if (in_valid && in_eoi)
        begin
            // flush the held token, then EOF, then back to reset state
            unique case (mode_reg)
                M_LT, M_LT_BANG, M_LT_BANG_DASH:
                begin
                    tk[n[1:0]] = mk(TK_LT, pst_reg, OB'(1), pline_reg, pcol_reg);
                    n = n + 3'd1;
                    if (mode_reg != M_LT)
                    begin
                        tk[n[1:0]] = mk(TK_STRAY, pst_reg + OB'(1), OB'(1), pline_reg, col1);
                        n = n + 3'd1;
                    end
                    if (mode_reg == M_LT_BANG_DASH)
                    begin
                        tk[n[1:0]] = mk(TK_STRAY, pst_reg + OB'(2), OB'(1), pline_reg,
                                        inc_sat(col1));
                        n = n + 3'd1;
                    end
                end
                M_SLASH, M_QUEST:
                begin
                    tk[n[1:0]] = mk(TK_STRAY, pst_reg, OB'(1), pline_reg, pcol_reg);
                    n = n + 3'd1;
                end
                M_NAME:
                begin
                    tk[n[1:0]] = mk(TK_NAME, pst_reg, upto, pline_reg, pcol_reg);
                    n = n + 3'd1;
                end
                M_STRING:
                begin
                    tk[n[1:0]] = mk(TK_STRING, pst_reg, upto, pline_reg, pcol_reg);
                    n = n + 3'd1;
                end
                M_TEXT:
                begin
                    tk[n[1:0]] = mk(TK_TEXT, pst_reg, upto, pline_reg, pcol_reg);
                    n = n + 3'd1;
                end
                M_COMMENT:
                begin
                    tk[n[1:0]] = mk(TK_COMMENT, pst_reg, upto, pline_reg, pcol_reg);
                    n = n + 3'd1;
                end
                default: ;
            endcase
            tk[n[1:0]] = mk(TK_EOF, off_reg, OB'(3), line_reg, inc_sat(col_reg));
            n = n + 3'd1;
            off_next = '0;
            line_next = 16'd1;
            col_next = '0;
            tag_next = 1'b0;
            mode_next = M_IDLE;
            pst_next = '0;
            pline_next = 16'd1;
            pcol_next = '0;
            dash_next = '0;
        end
        else if (in_valid)
        begin
            if (in_byte == CH_LF)
            begin
                ln = inc_sat(line_reg);
                cl = '0;
            end
            else
            begin
                cl = inc_sat(col_reg);
            end
            line_next = ln;
            col_next = cl;
            off_next = off_reg + OB'(1);

            unique case (mode_reg)
                M_SLASH, M_QUEST:
                begin
                    mode_next = M_IDLE;
                    if (in_byte == CH_GT)
                    begin
                        tk[n[1:0]] = mk((mode_reg == M_SLASH) ? TK_SL_GT : TK_Q_GT,
                                        pst_reg, OB'(2), pline_reg, pcol_reg);
                        n = n + 3'd1;
                        tag_next = 1'b0;
                    end
                    else
                    begin
                        tk[n[1:0]] = mk(TK_STRAY, pst_reg, OB'(1), pline_reg, pcol_reg);
                        n = n + 3'd1;
                        do_idle = 1'b1;
                    end
                end
                M_LT:
                begin
                    if (in_byte == CH_SLASH || in_byte == CH_QUEST)
                    begin
                        tk[n[1:0]] = mk((in_byte == CH_SLASH) ? TK_LT_SL : TK_LT_Q,
                                        pst_reg, OB'(2), pline_reg, pcol_reg);
                        n = n + 3'd1;
                        tag_next = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else if (in_byte == CH_BANG)
                        mode_next = M_LT_BANG;
                    else
                    begin
                        replay = 1'b1;
                        held = 2'd0;
                    end
                end
                M_LT_BANG:
                begin
                    if (in_byte == CH_DASH)
                        mode_next = M_LT_BANG_DASH;
                    else
                    begin
                        replay = 1'b1;
                        held = 2'd1;
                    end
                end
                M_LT_BANG_DASH:
                begin
                    if (in_byte == CH_DASH)
                    begin
                        mode_next = M_COMMENT;
                        dash_next = 2'd2;
                    end
                    else
                    begin
                        replay = 1'b1;
                        held = 2'd2;
                    end
                end
                M_NAME:
                begin
                    if (!is_name_char(in_byte))
                    begin
                        tk[n[1:0]] = mk(TK_NAME, pst_reg, upto, pline_reg, pcol_reg);
                        n = n + 3'd1;
                        mode_next = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (is_quote(in_byte))
                    begin
                        tk[n[1:0]] = mk(TK_STRING, pst_reg, thru, pline_reg, pcol_reg);
                        n = n + 3'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_TEXT:
                begin
                    if (in_byte == CH_LT)
                    begin
                        tk[n[1:0]] = mk(TK_TEXT, pst_reg, upto, pline_reg, pcol_reg);
                        n = n + 3'd1;
                        mode_next = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (in_byte == CH_DASH)
                        dash_next = (dash_reg == 2'd2) ? 2'd2 : dash_reg + 2'd1;
                    else if (in_byte == CH_GT && dash_reg == 2'd2)
                    begin
                        tk[n[1:0]] = mk(TK_COMMENT, pst_reg, thru, pline_reg, pcol_reg);
                        n = n + 3'd1;
                        mode_next = M_IDLE;
                        dash_next = '0;
                    end
                    else
                        dash_next = '0;
                end
                default:
                begin
                    mode_next = M_IDLE;
                    do_idle = 1'b1;
                end
            endcase

            // plain or broken-comment '<': '<', then held '!' / '-' as strays in the tag
            if (replay)
            begin
                tk[n[1:0]] = mk(TK_LT, pst_reg, OB'(1), pline_reg, pcol_reg);
                n = n + 3'd1;
                if (held != 2'd0)
                begin
                    tk[n[1:0]] = mk(TK_STRAY, pst_reg + OB'(1), OB'(1), pline_reg, col1);
                    n = n + 3'd1;
                end
                if (held == 2'd2)
                begin
                    tk[n[1:0]] = mk(TK_STRAY, pst_reg + OB'(2), OB'(1), pline_reg,
                                    inc_sat(col1));
                    n = n + 3'd1;
                end
                tag_next = 1'b1;
                mode_next = M_IDLE;
                do_idle = 1'b1;
            end

            if (do_idle && !(in_byte == CH_SP || in_byte == CH_TAB ||
                             in_byte == CH_LF || in_byte == CH_CR))
            begin
                if (in_byte == CH_GT)
                begin
                    tk[n[1:0]] = mk(TK_GT, off_reg, OB'(1), ln, cl);
                    n = n + 3'd1;
                    tag_next = 1'b0;
                end
                else if (in_byte == CH_EQ)
                begin
                    tk[n[1:0]] = mk(TK_EQ, off_reg, OB'(1), ln, cl);
                    n = n + 3'd1;
                end
                else if (in_byte == CH_LT || in_byte == CH_SLASH || in_byte == CH_QUEST ||
                         !tag_next || is_alpha(in_byte) || is_quote(in_byte))
                begin
                    pst_next = off_reg;
                    pline_next = ln;
                    pcol_next = cl;
                    if (in_byte == CH_LT)
                        mode_next = M_LT;
                    else if (in_byte == CH_SLASH)
                        mode_next = M_SLASH;
                    else if (in_byte == CH_QUEST)
                        mode_next = M_QUEST;
                    else if (!tag_next)
                        mode_next = M_TEXT;
                    else if (is_alpha(in_byte))
                        mode_next = M_NAME;
                    else
                        mode_next = M_STRING;
                end
                else
                begin
                    tk[n[1:0]] = mk(TK_STRAY, off_reg, OB'(1), ln, cl);
                    n = n + 3'd1;
                end
            end
        end

        bnd.cnt = n;
        bnd.tok = tk;
        bnd_valid = in_valid && (n != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            line_reg  <= 16'd1;
            col_reg   <= '0;
            tag_reg   <= 1'b0;
            mode_reg  <= M_IDLE;
            pst_reg   <= '0;
            pline_reg <= 16'd1;
            pcol_reg  <= '0;
            dash_reg  <= '0;
        end
        else
        begin
            off_reg   <= off_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tag_reg   <= tag_next;
            mode_reg  <= mode_next;
            pst_reg   <= pst_next;
            pline_reg <= pline_next;
            pcol_reg  <= pcol_next;
            dash_reg  <= dash_next;
        end
    end

endmodule

### design/xts_fifo.sv
// Short bundle queue between front and back.
module xts_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  xts_pkg::bundle_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic             nonempty,
    output xts_pkg::bundle_t rd_data
);
    import xts_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    bundle_t           mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]     wp_reg, wp_next;
    logic [AW-1:0]     rp_reg, rp_next;
    logic [AW:0]       cnt_reg, cnt_next;

    assign full     = (cnt_reg == (AW+1)'(QUEUE_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wr_en ? wp_reg + AW'(1) : wp_reg;
        rp_next  = rd_en ? rp_reg + AW'(1) : rp_reg;
        cnt_next = cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full && !rd_en))
        else $error("bundle queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> nonempty)
        else $error("bundle queue read while empty");
    a_nonzero_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_data.cnt != 3'd0 && wr_data.cnt <= 3'(MAX_TOKENS)))
        else $error("bundle with bad token count");
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (cnt_reg == $past(cnt_reg) + (AW+1)'(1)))
        else $error("queue count did not advance");

endmodule

### design/xts_back.sv
// Back end: walks the head bundle and presents one token per pop.
module xts_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_nonempty,
    input  xts_pkg::bundle_t q_head,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [3:0]       token_kind,
    output logic [23:0]      start_offset,
    output logic [23:0]      token_length,
    output logic [15:0]      start_line,
    output logic [15:0]      start_column,
    output logic             last_of_run
);
    import xts_pkg::*;

    logic [1:0] idx_reg, idx_next;
    token_t     cur;
    logic       last;

    assign cur   = q_head.tok[idx_reg];
    assign last  = ({1'b0, idx_reg} == q_head.cnt - 3'd1);
    assign empty = !q_nonempty;

    assign token_kind   = cur.kind;
    assign start_offset = cur.start;
    assign token_length = cur.len;
    assign start_line   = cur.line;
    assign start_column = cur.col;
    assign last_of_run  = last;

    always_comb
    begin
        q_pop    = 1'b0;
        idx_next = idx_reg;
        if (pop && q_nonempty)
        begin
            if (last)
            begin
                q_pop    = 1'b1;
                idx_next = '0;
            end
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        q_nonempty |-> ({1'b0, idx_reg} < q_head.cnt))
        else $error("token index past bundle end");
    a_idx_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !q_nonempty |-> (idx_reg == 2'd0))
        else $error("token index nonzero with queue empty");
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (pop && last_of_run))
        else $error("bundle dropped before its last token");

endmodule

### design/xml_token_scanner.sv
// Top level of the XML token scanner: front end, bundle queue and back end.
//
// Usage:
//  - Input queue: drive data_byte (or end_of_input=1) with push; an item is
//    taken on a clock edge with push high and full low, one byte per cycle.
//  - Result queue: while empty is low, the oldest token sits on the result
//    ports; pop high takes it. last_of_run marks the last token of an item.
//  - Each item yields zero to four tokens. The front decodes combinationally
//    and the bundle is written into the queue at the accepting edge; the
//    queue head drives the result ports.
//  - Throughput: one item per cycle while full is low, one token per cycle
//    out while pop is high. Multi-token items drain one token a cycle from
//    the back end; the four-bundle queue absorbs bursts, then full rises.
//  - end_of_input flushes the held token, emits EOF (length 3) and returns
//    the scanner to its reset state in the same cycle.
//  - Reset (rst_n low, asynchronous) clears position, mode and the queue.
//  - A stalled receiver (pop low) holds the current token steady; the front
//    keeps taking bytes until the queue fills.
module xml_token_scanner #(
    parameter int OFFSET_BITS = xts_pkg::OFFSET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  token_kind,
    output logic [23:0] start_offset,
    output logic [23:0] token_length,
    output logic [15:0] start_line,
    output logic [15:0] start_column,
    output logic        last_of_run
);
    import xts_pkg::*;

    logic    accept;
    logic    bnd_valid;
    bundle_t bnd;
    logic    q_nonempty;
    bundle_t q_head;
    logic    q_pop;

    // item accepted when push is high and the queue has room
    assign accept = push && !full;

    xts_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_byte   (data_byte),
        .in_eoi    (end_of_input),
        .bnd_valid (bnd_valid),
        .bnd       (bnd)
    );

    xts_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (bnd_valid),
        .wr_data  (bnd),
        .full     (full),
        .rd_en    (q_pop),
        .nonempty (q_nonempty),
        .rd_data  (q_head)
    );

    xts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_nonempty   (q_nonempty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .start_line   (start_line),
        .start_column (start_column),
        .last_of_run  (last_of_run)
    );

endmodule

### dv/xts_checker.sv
// Token predictor and scoreboard for the XML token scanner.
`timescale 1ns / 1ps

module xts_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,
    input  logic        empty,
    input  logic        pop,
    input  logic [3:0]  token_kind,
    input  logic [23:0] start_offset,
    input  logic [23:0] token_length,
    input  logic [15:0] start_line,
    input  logic [15:0] start_column,
    input  logic        last_of_run,
    output int          errors,
    output int          outstanding,
    output int          tokens_seen
);
    import xts_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [23:0] start;
        logic [23:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } exp_tok_t;

    exp_tok_t    expected_tokens[$];
    exp_tok_t    item_tokens[$];

    // scanner state copy
    logic [23:0] pos_off;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic        tag_open;
    mode_t       mode;
    logic [23:0] held_start;
    logic [15:0] held_line;
    logic [15:0] held_col;
    logic [1:0]  dashes;

    function automatic logic [15:0] sat_up(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_USCORE;
    endfunction

    function automatic logic name_byte(input logic [7:0] b);
        return letter(b) || (b >= "0" && b <= "9") || b == CH_COLON || b == CH_DASH;
    endfunction

    function automatic logic quote(input logic [7:0] b);
        return b == CH_DQ || b == CH_SQ;
    endfunction

    task automatic clear_state();
        pos_off    = '0;
        cur_line   = 16'd1;
        cur_col    = '0;
        tag_open   = 1'b0;
        mode       = M_IDLE;
        held_start = '0;
        held_line  = 16'd1;
        held_col   = '0;
        dashes     = '0;
    endtask

    task automatic add_tok(input kind_t k, input logic [23:0] s, input logic [23:0] n,
                           input logic [15:0] ln, input logic [15:0] cl);
        exp_tok_t t;
        t.kind = k; t.start = s; t.len = n; t.line = ln; t.col = cl; t.last = 1'b0;
        if (item_tokens.size() < MAX_TOKENS)
            item_tokens.push_back(t);
    endtask

    task automatic hold_at(input mode_t m, input logic [23:0] o, input logic [15:0] ln,
                           input logic [15:0] cl);
        mode = m; held_start = o; held_line = ln; held_col = cl;
    endtask

    // byte seen with nothing held
    task automatic scan_plain(input logic [7:0] b, input logic [23:0] o,
                              input logic [15:0] ln, input logic [15:0] cl);
        if (b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR)
            return;
        if (b == CH_GT) begin
            add_tok(TK_GT, o, 24'd1, ln, cl);
            tag_open = 1'b0;
        end
        else if (b == CH_EQ)    add_tok(TK_EQ, o, 24'd1, ln, cl);
        else if (b == CH_LT)    hold_at(M_LT, o, ln, cl);
        else if (b == CH_SLASH) hold_at(M_SLASH, o, ln, cl);
        else if (b == CH_QUEST) hold_at(M_QUEST, o, ln, cl);
        else if (!tag_open)     hold_at(M_TEXT, o, ln, cl);
        else if (letter(b))     hold_at(M_NAME, o, ln, cl);
        else if (quote(b))      hold_at(M_STRING, o, ln, cl);
        else                    add_tok(TK_STRAY, o, 24'd1, ln, cl);
    endtask

    // '<' that did not become a comment; held '!' and '-' go back through
    task automatic reopen_tag(input int held);
        logic [15:0] c1;
        c1 = sat_up(held_col);
        add_tok(TK_LT, held_start, 24'd1, held_line, held_col);
        tag_open = 1'b1;
        mode = M_IDLE;
        if (held >= 1) scan_plain(CH_BANG, held_start + 24'd1, held_line, c1);
        if (held >= 2) scan_plain(CH_DASH, held_start + 24'd2, held_line, sat_up(c1));
    endtask

    task automatic flush_held();
        logic [23:0] n;
        n = pos_off - held_start;
        case (mode)
            M_LT:           reopen_tag(0);
            M_LT_BANG:      reopen_tag(1);
            M_LT_BANG_DASH: reopen_tag(2);
            M_SLASH, M_QUEST: add_tok(TK_STRAY, held_start, 24'd1, held_line, held_col);
            M_NAME:    add_tok(TK_NAME, held_start, n, held_line, held_col);
            M_STRING:  add_tok(TK_STRING, held_start, n, held_line, held_col);
            M_TEXT:    add_tok(TK_TEXT, held_start, n, held_line, held_col);
            M_COMMENT: add_tok(TK_COMMENT, held_start, n, held_line, held_col);
            default: ;
        endcase
        mode = M_IDLE;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic [23:0] o,
                             input logic [15:0] ln, input logic [15:0] cl);
        logic [23:0] upto;
        logic [23:0] thru;
        upto = o - held_start;
        thru = o + 24'd1 - held_start;
        case (mode)
            M_LT: begin
                if (b == CH_SLASH || b == CH_QUEST) begin
                    add_tok(b == CH_SLASH ? TK_LT_SL : TK_LT_Q, held_start, 24'd2,
                            held_line, held_col);
                    tag_open = 1'b1;
                    mode = M_IDLE;
                    return;
                end
                if (b == CH_BANG) begin
                    mode = M_LT_BANG;
                    return;
                end
                reopen_tag(0);
            end
            M_LT_BANG: begin
                if (b == CH_DASH) begin
                    mode = M_LT_BANG_DASH;
                    return;
                end
                reopen_tag(1);
            end
            M_LT_BANG_DASH: begin
                if (b == CH_DASH) begin
                    mode = M_COMMENT;
                    dashes = 2'd2;
                    return;
                end
                reopen_tag(2);
            end
            M_SLASH, M_QUEST: begin
                mode = M_IDLE;
                add_tok(TK_STRAY, held_start, 24'd1, held_line, held_col);
            end
            M_NAME: begin
                if (name_byte(b))
                    return;
                add_tok(TK_NAME, held_start, upto, held_line, held_col);
                mode = M_IDLE;
            end
            M_STRING: begin
                if (quote(b)) begin
                    add_tok(TK_STRING, held_start, thru, held_line, held_col);
                    mode = M_IDLE;
                end
                return;
            end
            M_TEXT: begin
                if (b != CH_LT)
                    return;
                add_tok(TK_TEXT, held_start, upto, held_line, held_col);
                mode = M_IDLE;
            end
            M_COMMENT: begin
                if (b == CH_DASH)
                    dashes = (dashes >= 2'd2) ? 2'd2 : dashes + 2'd1;
                else if (b == CH_GT && dashes >= 2'd2) begin
                    add_tok(TK_COMMENT, held_start, thru, held_line, held_col);
                    mode = M_IDLE;
                    dashes = '0;
                end
                else
                    dashes = '0;
                return;
            end
            default: mode = M_IDLE;
        endcase
        scan_plain(b, o, ln, cl);
    endtask

    task automatic predict_item(input logic [7:0] b, input logic eoi);
        item_tokens.delete();
        if (eoi) begin
            flush_held();
            add_tok(TK_EOF, pos_off, 24'd3, cur_line, sat_up(cur_col));
            clear_state();
        end
        else begin
            if (b == CH_LF) begin
                cur_line = sat_up(cur_line);
                cur_col = '0;
            end
            else
                cur_col = sat_up(cur_col);
            if ((mode == M_SLASH || mode == M_QUEST) && b == CH_GT) begin
                add_tok(mode == M_SLASH ? TK_SL_GT : TK_Q_GT, held_start, 24'd2,
                        held_line, held_col);
                tag_open = 1'b0;
                mode = M_IDLE;
            end
            else
                take_byte(b, pos_off, cur_line, cur_col);
            pos_off = pos_off + 24'd1;
        end
        if (item_tokens.size() > 0)
            item_tokens[item_tokens.size()-1].last = 1'b1;
        foreach (item_tokens[i])
            expected_tokens.push_back(item_tokens[i]);
    endtask

    task automatic compare_field(input string what, input logic [23:0] exp_v,
                                 input logic [23:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
        outstanding = 0;
        tokens_seen = 0;
        clear_state();
    end

    always @(posedge clk)
    begin
        exp_tok_t e;
        if (rst_n) begin
            if (pop && !empty) begin
                tokens_seen++;
                if (expected_tokens.size() == 0) begin
                    $display("%0t: unexpected token, expected none, actual kind %0d offset %0d",
                             $time, token_kind, start_offset);
                    errors++;
                end
                else begin
                    e = expected_tokens.pop_front();
                    compare_field("kind", 24'(e.kind), 24'(token_kind));
                    compare_field("start_offset", e.start, start_offset);
                    compare_field("length", e.len, token_length);
                    compare_field("line", 24'(e.line), 24'(start_line));
                    compare_field("column", 24'(e.col), 24'(start_column));
                    compare_field("last_of_run", 24'(e.last), 24'(last_of_run));
                end
            end
            if (push && !full)
                predict_item(data_byte, end_of_input);
        end
        outstanding = expected_tokens.size();
    end

endmodule

### dv/tb_top.sv
// Testbench top for the XML token scanner: stimulus, pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
    import xts_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        end_of_input = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [3:0]  token_kind;
    logic [23:0] start_offset;
    logic [23:0] token_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        last_of_run;

    int errors;
    int outstanding;
    int tokens_seen;

    // calm: neither side idles; stall_req: receiver takes one long hold-off
    bit  calm = 1'b0;
    bit  stall_req = 1'b0;
    int  items_sent = 0;
    int  docs_sent = 0;

    // pending stimulus: bit 8 marks end of input
    logic [8:0] doc[$];

    always #2 clk = ~clk;

    xml_token_scanner dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .end_of_input(end_of_input),
        .empty(empty), .pop(pop), .token_kind(token_kind),
        .start_offset(start_offset), .token_length(token_length),
        .start_line(start_line), .start_column(start_column),
        .last_of_run(last_of_run)
    );

    xts_checker chk (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .end_of_input(end_of_input),
        .empty(empty), .pop(pop), .token_kind(token_kind),
        .start_offset(start_offset), .token_length(token_length),
        .start_line(start_line), .start_column(start_column),
        .last_of_run(last_of_run), .errors(errors),
        .outstanding(outstanding), .tokens_seen(tokens_seen)
    );

    // Receiver: pops about 79% of cycles; one long hold-off on request.
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= calm || ($urandom_range(99) >= 21);
        end
    end

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input logic [7:0] b, input logic eoi);
        while (!calm && $urandom_range(99) < 21) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        if (eoi)
            docs_sent++;
    endtask

    task automatic add_str(input string s);
        foreach (s[i])
            doc.push_back({1'b0, s[i]});
    endtask

    task automatic add_name();
        int n;
        n = $urandom_range(5);
        case ($urandom_range(2))
            0: doc.push_back({1'b0, 8'("a") + 8'($urandom_range(25))});
            1: doc.push_back({1'b0, 8'("A") + 8'($urandom_range(25))});
            default: doc.push_back({1'b0, CH_USCORE});
        endcase
        repeat (n) begin
            case ($urandom_range(4))
                0: doc.push_back({1'b0, 8'("0") + 8'($urandom_range(9))});
                1: doc.push_back({1'b0, CH_COLON});
                2: doc.push_back({1'b0, CH_DASH});
                default: doc.push_back({1'b0, 8'("a") + 8'($urandom_range(25))});
            endcase
        end
    endtask

    task automatic add_quoted();
        doc.push_back({1'b0, $urandom_range(1) ? CH_DQ : CH_SQ});
        repeat ($urandom_range(4))
            doc.push_back({1'b0, 8'("a") + 8'($urandom_range(25))});
        doc.push_back({1'b0, $urandom_range(1) ? CH_DQ : CH_SQ});
    endtask

    // One random document fragment, mostly well formed.
    task automatic add_fragment();
        case ($urandom_range(13))
            0, 1: begin
                add_str("<");
                add_name();
                repeat ($urandom_range(2)) begin
                    add_str(" ");
                    add_name();
                    add_str("=");
                    add_quoted();
                end
                add_str($urandom_range(3) == 0 ? "/>" : ">");
            end
            2: begin
                add_str("</");
                add_name();
                add_str(">");
            end
            3, 4: begin
                repeat ($urandom_range(1, 6))
                    doc.push_back({1'b0, $urandom_range(5) == 0 ? CH_LF
                                         : 8'($urandom_range(8'h20, 8'h7E) & 8'hFB | 8'h01)});
            end
            5: begin
                add_str("<!--");
                repeat ($urandom_range(4))
                    add_str($urandom_range(2) == 0 ? "-" : "x");
                add_str("-->");
            end
            6: begin
                add_str("<?");
                add_name();
                add_str(" ");
                add_name();
                add_str("?>");
            end
            7: add_str($urandom_range(1) ? "<!" : "<!-");
            8: add_str($urandom_range(1) ? "/" : "?");
            9, 10: doc.push_back({1'b0, 8'($urandom_range(255))});
            11: add_str($urandom_range(1) ? " \t" : "\r\n");
            12: add_quoted();
            default: doc.push_back({1'b1, 8'($urandom_range(255))});
        endcase
    endtask

    task automatic drain_doc();
        logic [8:0] v;
        while (doc.size() > 0) begin
            v = doc.pop_front();
            send_item(v[7:0], v[8]);
        end
    endtask

    initial
    begin
        int random_items;
        bit paused;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every punctuation, either quote closing a string,
        // zero and all-ones bytes, empty comment, broken opener, strays.
        add_str("<?p?><a b='\"/>t");
        doc.push_back({1'b0, 8'h00});
        doc.push_back({1'b0, 8'hFF});
        add_str("<!-->\n<!x<!-=</q>?z");
        doc.push_back({1'b1, 8'h00});
        drain_doc();

        // Back-to-back burst with no idling on either side.
        calm = 1'b1;
        repeat (4) add_fragment();
        drain_doc();
        calm = 1'b0;

        // Random documents. Partway in the receiver holds off so the
        // queue fills; later the sender pauses until all tokens are out.
        random_items = 0;
        paused = 1'b0;
        while (random_items < 260) begin
            add_fragment();
            random_items += doc.size();
            if (random_items > 60 && !stall_req)
                stall_req = 1'b1;
            if (random_items > 150 && !paused) begin
                paused = 1'b1;
                push <= 1'b0;
                @(posedge clk);
                wait (outstanding == 0);
            end
            drain_doc();
        end
        doc.push_back({1'b1, 8'h00});
        drain_doc();
        push <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (20) @(posedge clk);

        $display("Sent %0d items in %0d documents, checked %0d tokens.",
                 items_sent, docs_sent, tokens_seen);
        $display("Covered all token kinds, broken openers, a full-queue stall and a drain.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout with %0d tokens outstanding", outstanding);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
